// ===== rtl/row_median_by_sorting_macros.svh =====
// Assertion macros shared by the row median modules.
// Each macro expects i_clk and i_rst_n to exist in the module that uses it.
`ifndef ROW_MEDIAN_BY_SORTING_MACROS_SVH
`define ROW_MEDIAN_BY_SORTING_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RMBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rmbs_pkg.sv =====
`default_nettype none
package rmbs_pkg;

    localparam int MAX_ROW_DEFAULT = 32;
    localparam int SAMPLE_W        = 16;
    localparam int MEDIAN_W        = 17;
    localparam int COUNT_W         = 6;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_rmbs_in;

    typedef struct packed {
        logic signed [MEDIAN_W-1:0] median_twice;
        logic [COUNT_W-1:0]         count;
    } t_rmbs_out;

    typedef enum logic [1:0] {
        S_LOAD,
        S_PREP,
        S_SHIFT,
        S_DONE
    } t_rmbs_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // an input item is transferred this cycle
        logic shift_load;  // set up the shift counter from the row count
        logic shift;       // move the chain down by one cell
        logic finish;      // capture the result and clear the row
    } t_rmbs_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic shift_done;  // the middle values sit in the two lowest cells
    } t_rmbs_status;

endpackage
`default_nettype wire

// ===== rtl/rmbs_datapath.sv =====
`default_nettype none
`include "row_median_by_sorting_macros.svh"
module rmbs_datapath
    import rmbs_pkg::*;
#(
    parameter int MAX_ROW = MAX_ROW_DEFAULT
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_rmbs_cmd    i_cmd,
    input  wire t_rmbs_in     i_item,
    output t_rmbs_status      o_status,
    output t_rmbs_out         o_result
);

    localparam int CW = $clog2(MAX_ROW + 1);
    localparam int SW = ($clog2(MAX_ROW) > 0) ? $clog2(MAX_ROW) : 1;

    // Sorted insertion chain; the valid prefix is the first r_count cells.
    logic signed [SAMPLE_W-1:0] r_cell [MAX_ROW];
    logic signed [SAMPLE_W-1:0] n_cell [MAX_ROW];
    logic [CW-1:0]              r_count, n_count;
    logic                       r_zero_seen, n_zero_seen;
    logic [SW-1:0]              r_shift, n_shift;
    t_rmbs_out                  r_result, n_result;

    logic [MAX_ROW-1:0]         gt_v;
    logic [CW-1:0]              count_m1;
    logic signed [MEDIAN_W-1:0] pair_sum;
    logic                       do_insert;

    always_comb begin
        // A cell moves up when it lies beyond the valid prefix or holds a larger value.
        for (int i = 0; i < MAX_ROW; i++) begin
            gt_v[i] = (CW'(i) >= r_count) || (r_cell[i] > i_item.sample);
        end
        count_m1  = r_count - CW'(1);
        pair_sum  = MEDIAN_W'(r_cell[0]) + MEDIAN_W'(r_cell[1]);
        do_insert = i_cmd.load && !r_zero_seen && (i_item.sample != '0)
                    && (r_count < CW'(MAX_ROW));

        n_cell      = r_cell;
        n_count     = r_count;
        n_zero_seen = r_zero_seen;
        n_shift     = r_shift;
        n_result    = r_result;

        if (i_cmd.load && !r_zero_seen && (i_item.sample == '0)) begin
            n_zero_seen = 1'b1;
        end
        if (do_insert) begin
            n_count   = r_count + CW'(1);
            n_cell[0] = gt_v[0] ? i_item.sample : r_cell[0];
            for (int i = 1; i < MAX_ROW; i++) begin
                if (gt_v[i-1]) begin
                    n_cell[i] = r_cell[i-1];
                end else if (gt_v[i]) begin
                    n_cell[i] = i_item.sample;
                end
            end
        end

        // Dropping (count - 1) / 2 cells brings the middle value(s) to cells 0 and 1.
        if (i_cmd.shift_load) begin
            n_shift = (r_count == '0) ? '0 : SW'(count_m1 >> 1);
        end
        if (i_cmd.shift) begin
            n_shift = r_shift - SW'(1);
            for (int i = 0; i < MAX_ROW - 1; i++) begin
                n_cell[i] = r_cell[i+1];
            end
        end

        if (i_cmd.finish) begin
            if (r_count == '0) begin
                n_result.median_twice = '0;
            end else if (r_count[0]) begin
                n_result.median_twice = {r_cell[0], 1'b0};
            end else begin
                n_result.median_twice = pair_sum;
            end
            n_result.count = COUNT_W'(r_count);
            n_count        = '0;
            n_zero_seen    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_zero_seen <= 1'b0;
            r_shift     <= '0;
        end else begin
            r_count     <= n_count;
            r_zero_seen <= n_zero_seen;
            r_shift     <= n_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell   <= n_cell;
        r_result <= n_result;
    end

    assign o_status.shift_done = (r_shift == '0);
    assign o_result            = r_result;

    `RMBS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(MAX_ROW), "row count beyond MAX_ROW")

endmodule
`default_nettype wire

// ===== rtl/rmbs_ctrl.sv =====
`default_nettype none
`include "row_median_by_sorting_macros.svh"
module rmbs_ctrl
    import rmbs_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    input  wire logic         i_in_last,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    input  wire t_rmbs_status i_status,
    output t_rmbs_cmd         o_cmd
);

    t_rmbs_state r_state, n_state;
    logic        r_out_valid, n_out_valid;
    logic        accept;
    logic        slot_free;

    assign accept    = i_in_valid && (r_state == S_LOAD);
    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:  if (accept && i_in_last) begin
                n_state = S_PREP;
            end
            S_PREP:  n_state = S_SHIFT;
            S_SHIFT: if (i_status.shift_done) begin
                n_state = S_DONE;
            end
            S_DONE:  if (slot_free) begin
                n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_LOAD:  o_cmd.load       = accept;
            S_PREP:  o_cmd.shift_load = 1'b1;
            S_SHIFT: o_cmd.shift      = !i_status.shift_done;
            S_DONE:  o_cmd.finish     = slot_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;

    `RMBS_ASSERT_NOW(a_finish_slot, o_cmd.finish, slot_free, "result overwritten")
    `RMBS_ASSERT_NOW(a_valid_source, $rose(r_out_valid), $past(r_state == S_DONE), "stray result")
    `RMBS_ASSERT_NEXT(a_last_ends_row, accept && i_in_last, r_state == S_PREP, "no median phase")

endmodule
`default_nettype wire

// ===== rtl/row_median_by_sorting.sv =====
//  Channel   Direction  Handshake                       Payload
//  input     in         i_in_valid / o_in_stall         i_in_item  (sample, last)
//  output    out        o_out_valid / i_out_stall       o_out_item (median_twice, count)
//
//  While a row streams in, one element is transferred per cycle and lands in sorted place.
//  After the last element the input stalls while the shift count is set up, the chain
//  shifts down until the middle values sit lowest, and the result is captured.
//  The result register frees the chain, so the next row may load while a result waits.
//  A stalled result holds, and the next row end waits in its final step until it leaves.
//  Reset is synchronous and active low; the chain cells and the result are not reset.
`default_nettype none
module row_median_by_sorting
    import rmbs_pkg::*;
#(
    parameter int MAX_ROW = MAX_ROW_DEFAULT
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_rmbs_in  i_in_item,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output t_rmbs_out      o_out_item,
    input  wire logic      i_out_stall
);

    // Commands and status join the controller to the datapath and nothing else.
    t_rmbs_cmd    cmd;
    t_rmbs_status status;

    // The controller sequences loading, the shift-down phase and the result transfer.
    rmbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_item.last),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath holds the sorted chain, the row count and the result register.
    rmbs_datapath #(
        .MAX_ROW (MAX_ROW)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_in_item),
        .o_status (status),
        .o_result (o_out_item)
    );

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
module tb_top import rmbs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // The instance keeps its default row capacity, so the model of the sorting
    // chain saturates at the same depth.
    localparam int ROW_CAP      = MAX_ROW_DEFAULT;
    localparam int RANDOM_ITEMS = 1050;
    localparam int DRAIN_CYCLES = 60;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_rmbs_in  i_in_item;
    logic      o_in_stall;
    logic      o_out_valid;
    t_rmbs_out o_out_item;
    logic      i_out_stall;

    row_median_by_sorting u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    // 20 ns clock, first rising edge at 10 ns.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Shadow of the sorting chain for the row that is being loaded. Values sit in
    // ascending order, and the flag records that a zero already closed the row.
    logic signed [SAMPLE_W-1:0] row_sorted[$];
    bit                         row_zero_seen;

    // Medians that have been predicted but not yet seen on the output channel.
    t_rmbs_out pending_medians[$];
    t_rmbs_out wanted_median;

    int fail_count;
    int useful_items;
    int burst_left;
    int stall_mode;
    int stall_phase_left;

    // Directed rows. Only a row's final element carries a typed result, and only
    // where the answer is obvious; all other rows rely on the sorting model below.
    typedef struct {
        t_rmbs_in  item;
        bit        known;
        t_rmbs_out known_out;
    } t_directed_step;

    t_directed_step directed_steps[] = '{
        // Empty row: a lone zero that is also the row end.
        '{{16'h0000, 1'b1}, 1'b1, {17'h00000, 6'd0}},
        // Single element at each extreme of the sample range.
        '{{16'h7fff, 1'b1}, 1'b1, {17'h0fffe, 6'd1}},
        '{{16'h8000, 1'b1}, 1'b1, {17'h10000, 6'd1}},
        // Even rows built from the extremes: largest and smallest sums, then -1.
        '{{16'h7fff, 1'b0}, 1'b0, {17'h00000, 6'd0}},
        '{{16'h7fff, 1'b1}, 1'b1, {17'h0fffe, 6'd2}},
        '{{16'h8000, 1'b0}, 1'b0, {17'h00000, 6'd0}},
        '{{16'h8000, 1'b1}, 1'b1, {17'h10000, 6'd2}},
        '{{16'h7fff, 1'b0}, 1'b0, {17'h00000, 6'd0}},
        '{{16'h8000, 1'b1}, 1'b1, {17'h1ffff, 6'd2}},
        // Odd row that arrives out of order.
        '{{16'h0004, 1'b0}, 1'b0, {17'h00000, 6'd0}},
        '{{16'hffff, 1'b0}, 1'b0, {17'h00000, 6'd0}},
        '{{16'h0002, 1'b1}, 1'b0, {17'h00000, 6'd0}},
        // A zero in the middle: everything after it is dropped, the end included.
        '{{16'h0009, 1'b0}, 1'b0, {17'h00000, 6'd0}},
        '{{16'h0000, 1'b0}, 1'b0, {17'h00000, 6'd0}},
        '{{16'h0003, 1'b0}, 1'b0, {17'h00000, 6'd0}},
        '{{16'h7fff, 1'b1}, 1'b1, {17'h00012, 6'd1}},
        // The row end itself is a zero.
        '{{16'h0006, 1'b0}, 1'b0, {17'h00000, 6'd0}},
        '{{16'h0002, 1'b0}, 1'b0, {17'h00000, 6'd0}},
        '{{16'h0000, 1'b1}, 1'b0, {17'h00000, 6'd0}},
        // Leading zero, then a value that must be ignored.
        '{{16'h0000, 1'b0}, 1'b0, {17'h00000, 6'd0}},
        '{{16'h1234, 1'b1}, 1'b1, {17'h00000, 6'd0}},
        // Mixed signs, even count of four.
        '{{16'hfffe, 1'b0}, 1'b0, {17'h00000, 6'd0}},
        '{{16'h0003, 1'b0}, 1'b0, {17'h00000, 6'd0}},
        '{{16'h8001, 1'b0}, 1'b0, {17'h00000, 6'd0}},
        '{{16'h0010, 1'b1}, 1'b0, {17'h00000, 6'd0}}
    };

    // Folds one transferred element into the shadow chain. Returns 1 when the
    // element ends the row, with the expected result in res. acted tells whether
    // the element still mattered, i.e. no zero had closed the row before it.
    function automatic bit sort_into_row(input t_rmbs_in it, output t_rmbs_out res,
                                         output bit acted);
        int pos;
        int half;
        int twice;
        acted = !row_zero_seen;
        res   = '0;
        if (!row_zero_seen) begin
            if (it.sample == '0) begin
                row_zero_seen = 1'b1;
            end else if (row_sorted.size() < ROW_CAP) begin
                // Walk down from the top like the insertion chain does; equal
                // values stay below the newcomer.
                pos = row_sorted.size();
                while (pos > 0 && row_sorted[pos-1] > $signed(it.sample)) begin
                    pos--;
                end
                row_sorted.insert(pos, it.sample);
            end
        end
        if (!it.last) begin
            return 1'b0;
        end
        twice = 0;
        if (row_sorted.size() > 0) begin
            half = row_sorted.size() / 2;
            if (row_sorted.size() % 2 == 1) begin
                twice = 2 * int'(row_sorted[half]);
            end else begin
                twice = int'(row_sorted[half-1]) + int'(row_sorted[half]);
            end
        end
        res.median_twice = twice[MEDIAN_W-1:0];
        res.count        = COUNT_W'(row_sorted.size());
        row_sorted.delete();
        row_zero_seen = 1'b0;
        return 1'b1;
    endfunction

    // Sends one element. The sender runs in bursts: when a burst is used up, valid
    // drops for a random gap and a new burst length is drawn. Some bursts are long
    // so that whole rows stream without a break. Valid is held with a stable
    // payload until the block stops stalling, and the model is updated at the
    // edge where the transfer happens.
    task automatic transfer_item(input t_rmbs_in it, input bit known,
                                 input t_rmbs_out known_out);
        t_rmbs_out predicted;
        bit        acted;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        burst_left--;
        if (sort_into_row(it, predicted, acted)) begin
            pending_medians.push_back(known ? known_out : predicted);
        end
        if (acted || it.last) begin
            useful_items++;
        end
    endtask

    // Output side: checks every transfer against the oldest prediction and drives
    // the stall from a pattern whose character is drawn anew after each random-length
    // phase: no stall at all, rare stalls, mostly stalled, or strict alternation.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_medians.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, median_twice %0d count %0d",
                         $time, $signed(o_out_item.median_twice), o_out_item.count);
            end else begin
                wanted_median = pending_medians.pop_front();
                if (o_out_item.median_twice !== wanted_median.median_twice) begin
                    fail_count++;
                    $display("%0t: median_twice expected %0d, got %0d", $time,
                             $signed(wanted_median.median_twice),
                             $signed(o_out_item.median_twice));
                end
                if (o_out_item.count !== wanted_median.count) begin
                    fail_count++;
                    $display("%0t: count expected %0d, got %0d", $time,
                             wanted_median.count, o_out_item.count);
                end
            end
        end
        if (stall_phase_left == 0) begin
            stall_mode       = $urandom_range(0, 3);
            stall_phase_left = $urandom_range(16, 80);
        end else begin
            stall_phase_left--;
        end
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 5) == 0);
            end
            2: begin
                i_out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_out_stall <= ~i_out_stall;
            end
        endcase
    end

    // Main sequence: reset, directed rows, random rows, drain, verdict.
    initial begin
        t_rmbs_in item;
        int       row_len;
        int       zero_at;
        int       len_pick;
        int       mag;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_in_item        = '0;
        i_out_stall      = 1'b0;
        row_zero_seen    = 1'b0;
        fail_count       = 0;
        useful_items     = 0;
        burst_left       = 0;
        stall_mode       = 0;
        stall_phase_left = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[i]) begin
            transfer_item(directed_steps[i].item, directed_steps[i].known,
                          directed_steps[i].known_out);
        end

        // Random rows. Most rows are short and fully counted; some run past the
        // chain capacity so the count saturates, and about one in five is cut by
        // a zero at a random place, which may be the first or the last element.
        useful_items = 0;
        while (useful_items < RANDOM_ITEMS) begin
            len_pick = $urandom_range(0, 99);
            if (len_pick < 70) begin
                row_len = $urandom_range(1, 8);
            end else if (len_pick < 85) begin
                row_len = $urandom_range(9, 24);
            end else begin
                row_len = $urandom_range(28, 45);
            end
            zero_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, row_len - 1) : -1;
            for (int k = 0; k < row_len; k++) begin
                item.last = (k == row_len - 1);
                if (k == zero_at) begin
                    item.sample = '0;
                end else begin
                    // Small magnitudes give plenty of duplicates; values near the
                    // rails exercise the 17-bit sum at both ends.
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: begin
                            item.sample = 16'($urandom());
                        end
                        4, 5, 6: begin
                            mag = $urandom_range(1, 8);
                            item.sample = ($urandom_range(0, 1) == 1) ? 16'(-mag) : 16'(mag);
                        end
                        7: begin
                            case ($urandom_range(0, 3))
                                0: item.sample = 16'h7fff;
                                1: item.sample = 16'h8000;
                                2: item.sample = 16'h7ffe;
                                default: item.sample = 16'h8001;
                            endcase
                        end
                        default: begin
                            mag = $urandom_range(0, 255);
                            item.sample = ($urandom_range(0, 1) == 1) ? 16'(16'h7fff - mag)
                                                                       : 16'(16'h8000 + mag);
                        end
                    endcase
                end
                transfer_item(item, 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;

        // Every row ended with a final element, so once the queue is empty the
        // block holds nothing; the extra cycles catch any stray result.
        while (pending_medians.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
